// ===== sv/assert_macros.svh =====
// assertion macros shared by the steric clash factor rtl
// depends on signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/scf_pkg.sv =====
// shared widths, constants and unit request types for the steric clash factor
// no dependencies
package scf_pkg;

  // fixed point format
  localparam int F = 12;

  localparam int COORD_W  = 23;
  localparam int RAD_W    = 16;
  localparam int MAG_W    = COORD_W + 1;
  localparam int D2_W     = 2 * MAG_W;
  localparam int ROOT_W   = D2_W / 2;
  localparam int SUM_W    = RAD_W + 1;
  localparam int RECIP_W  = 2 * F + 1;
  localparam int DIFF_W   = 32;
  localparam int DCW      = (RECIP_W > DIFF_W) ? RECIP_W : DIFF_W;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int TERM_W   = PROD_W - F - 1;
  localparam int SCORE_W  = 48;
  localparam int DEN_W    = SCORE_W + 1;
  localparam int FACT_W   = 17;

  // iterative unit datapath
  localparam int DV_W  = DEN_W + 1;
  localparam int RW    = DV_W + 1;
  localparam int QW    = (RECIP_W > ROOT_W) ? RECIP_W : ROOT_W;
  localparam int CNT_W = 6;

  localparam logic [SCORE_W-1:0] SCORE_MAX  = {SCORE_W{1'b1}};
  localparam logic [DIFF_W-1:0]  DIFF_MAX   = {DIFF_W{1'b1}};
  localparam logic [FACT_W-1:0]  FACT_ONE   = FACT_W'(1) << 16;
  localparam logic [RAD_W-1:0]   PROBE_RST  = RAD_W'(1) << F;
  localparam logic [DV_W-1:0]    ONE2_SRC   = DV_W'(1) << (2 * F + DV_W - RECIP_W);
  localparam logic [DV_W-1:0]    FNUM       = DV_W'(1) << (16 + F);
  localparam logic [DV_W-1:0]    FONE       = DV_W'(1) << F;

  localparam logic [CNT_W-1:0] STEPS_ROOT  = CNT_W'(ROOT_W);
  localparam logic [CNT_W-1:0] STEPS_RECIP = CNT_W'(RECIP_W);
  localparam logic [CNT_W-1:0] STEPS_FACT  = CNT_W'(FACT_W);

  // request to the shared divide / square root unit
  typedef struct packed {
    logic             start;
    logic             sqrt;
    logic [RW-1:0]    rem_init;
    logic [DV_W-1:0]  src;
    logic [RW-1:0]    divisor;
    logic [CNT_W-1:0] nsteps;
  } unit_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quot;
  } unit_rsp_t;

endpackage

// ===== sv/scf_divsqrt.sv =====
// shared iterative unit: restoring division or digit by digit square root
// one quotient or root bit per cycle; depends on scf_pkg
module scf_divsqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  scf_pkg::unit_req_t  req,
  output scf_pkg::unit_rsp_t  rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        sqrt_r;
  logic [scf_pkg::RW-1:0]      rem_r, rem_nxt;
  logic [scf_pkg::DV_W-1:0]    src_r, src_nxt;
  logic [scf_pkg::RW-1:0]      div_r;
  logic [scf_pkg::QW-1:0]      q_r, q_nxt;
  logic [scf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [scf_pkg::RW-1:0]      rem_sh;
  logic [scf_pkg::RW-1:0]      trial;
  logic [scf_pkg::RW-1:0]      q_ext;
  logic                        ge;

  // one compare and subtract step
  always_comb begin
    q_ext = scf_pkg::RW'(q_r);
    if (sqrt_r) begin
      rem_sh = {rem_r[scf_pkg::RW-3:0], src_r[scf_pkg::DV_W-1 -: 2]};
      trial  = {q_ext[scf_pkg::RW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[scf_pkg::RW-2:0], src_r[scf_pkg::DV_W-1]};
      trial  = div_r;
    end
    ge = (rem_sh >= trial);
  end

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem_init;
      src_nxt  = req.src;
      q_nxt    = '0;
      cnt_nxt  = req.nsteps;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
      src_nxt = sqrt_r ? (src_r << 2) : (src_r << 1);
      q_nxt   = {q_r[scf_pkg::QW-2:0], ge};
      cnt_nxt = cnt_r - scf_pkg::CNT_W'(1);
      if (cnt_r == scf_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    src_r <= src_nxt;
    q_r   <= q_nxt;
    if (req.start) begin
      sqrt_r <= req.sqrt;
      div_r  <= req.divisor;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== sv/scf_square.sv =====
// shared registered squaring unit for coordinate and difference squares
// depends on scf_pkg
module scf_square (
  input  logic                         clk,
  input  logic [scf_pkg::DIFF_W-1:0]   op,
  output logic [scf_pkg::PROD_W-1:0]   sq_r
);

  logic [scf_pkg::PROD_W-1:0] sq_nxt;

  // one 32 by 32 multiply, registered
  assign sq_nxt = scf_pkg::PROD_W'(op) * scf_pkg::PROD_W'(op);

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

endmodule

// ===== sv/steric_clash_factor.sv =====
// a clashing atom holds the block from its accept through the squares, 24 root steps,
// two 25-step reciprocals and the accumulate; an atom without a clash frees it after the root
// throughput: one transaction at a time, the next accept comes once the block is free
// an item without an atom that is not last frees the block on the next cycle; a last item adds
// the 17-step factor division and the output load before out_valid rises, which out_stall can hold
// reset: synchronous active low, clears score, flag, probe radius to 1.0, out_valid
`include "assert_macros.svh"
module steric_clash_factor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [scf_pkg::RAD_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [scf_pkg::COORD_W-1:0] in_atom_x,
  input  logic signed [scf_pkg::COORD_W-1:0] in_atom_y,
  input  logic signed [scf_pkg::COORD_W-1:0] in_atom_z,
  input  logic [scf_pkg::RAD_W-1:0]      in_atom_radius,
  input  logic signed [scf_pkg::COORD_W-1:0] in_probe_x,
  input  logic signed [scf_pkg::COORD_W-1:0] in_probe_y,
  input  logic signed [scf_pkg::COORD_W-1:0] in_probe_z,
  input  logic                           in_atom_present,
  input  logic                           in_last_atom,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [scf_pkg::FACT_W-1:0]     out_clash_factor,
  output logic                           out_score_saturated
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQ_X   = 4'd1;
  localparam logic [3:0] ST_SQ_Y   = 4'd2;
  localparam logic [3:0] ST_SQ_Z   = 4'd3;
  localparam logic [3:0] ST_SQ_ACC = 4'd4;
  localparam logic [3:0] ST_ROOT   = 4'd5;
  localparam logic [3:0] ST_ROOT_W = 4'd6;
  localparam logic [3:0] ST_RD     = 4'd7;
  localparam logic [3:0] ST_RD_W   = 4'd8;
  localparam logic [3:0] ST_RS     = 4'd9;
  localparam logic [3:0] ST_RS_W   = 4'd10;
  localparam logic [3:0] ST_TERM   = 4'd11;
  localparam logic [3:0] ST_ACCUM  = 4'd12;
  localparam logic [3:0] ST_FACT   = 4'd13;
  localparam logic [3:0] ST_FACT_W = 4'd14;
  localparam logic [3:0] ST_EMIT   = 4'd15;

  logic [3:0]                       state_r, state_nxt;
  logic [scf_pkg::RAD_W-1:0]        probe_r;
  logic [scf_pkg::SCORE_W-1:0]      score_r, score_nxt;
  logic                             sat_r, sat_nxt;
  logic                             last_r;
  logic [scf_pkg::MAG_W-1:0]        mag_x_r, mag_y_r, mag_z_r;
  logic [scf_pkg::SUM_W-1:0]        s_r;
  logic [scf_pkg::D2_W-1:0]         d2_r;
  logic [scf_pkg::SUM_W-1:0]        d_r;
  logic [scf_pkg::RECIP_W-1:0]      inv_d_r, inv_s_r;
  logic [scf_pkg::FACT_W-1:0]       fact_r;
  logic                             out_valid_r;
  logic [scf_pkg::FACT_W-1:0]       out_fact_r;
  logic                             out_sat_r;

  logic                             in_acc;
  logic                             out_load;
  logic [scf_pkg::MAG_W-1:0]        dx, dy, dz;
  logic [scf_pkg::DIFF_W-1:0]       sq_op;
  logic [scf_pkg::PROD_W-1:0]       sq_r;
  logic [scf_pkg::ROOT_W-1:0]       root;
  logic [scf_pkg::RECIP_W-1:0]      diff_full;
  logic [scf_pkg::DCW-1:0]          diff_wide;
  logic [scf_pkg::DIFF_W-1:0]       diff_cl;
  logic [scf_pkg::TERM_W-1:0]       term;
  logic [scf_pkg::PROD_W:0]         sum_wide;
  logic [scf_pkg::DEN_W-1:0]        den;
  logic [scf_pkg::DV_W-1:0]         fdiv;
  scf_pkg::unit_req_t               req;
  scf_pkg::unit_rsp_t               rsp;

  function automatic logic [scf_pkg::DIFF_W-1:0] diff_cl_trunc(
    input logic [scf_pkg::DCW-1:0] v
  );
    diff_cl_trunc = v[scf_pkg::DIFF_W-1:0];
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // coordinate difference magnitudes at accept
  always_comb begin
    dx = scf_pkg::MAG_W'(in_atom_x) - scf_pkg::MAG_W'(in_probe_x);
    dy = scf_pkg::MAG_W'(in_atom_y) - scf_pkg::MAG_W'(in_probe_y);
    dz = scf_pkg::MAG_W'(in_atom_z) - scf_pkg::MAG_W'(in_probe_z);
    if (in_atom_x < in_probe_x) dx = -dx;
    if (in_atom_y < in_probe_y) dy = -dy;
    if (in_atom_z < in_probe_z) dz = -dz;
  end

  // shared units
  scf_square u_square (
    .clk  (clk),
    .op   (sq_op),
    .sq_r (sq_r)
  );

  scf_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // arithmetic around the units
  always_comb begin
    root      = rsp.quot[scf_pkg::ROOT_W-1:0];
    diff_full = inv_d_r - inv_s_r;
    diff_wide = scf_pkg::DCW'(diff_full);
    diff_cl   = (diff_wide > scf_pkg::DCW'(scf_pkg::DIFF_MAX)) ? scf_pkg::DIFF_MAX
                                                               : diff_cl_trunc(diff_wide);
    term      = sq_r[scf_pkg::PROD_W-1:scf_pkg::F+1];
    sum_wide  = (scf_pkg::PROD_W+1)'(score_r) + (scf_pkg::PROD_W+1)'(term);
    den       = scf_pkg::DEN_W'(scf_pkg::FONE) + scf_pkg::DEN_W'(score_r);
    fdiv      = scf_pkg::FNUM + scf_pkg::DV_W'(den >> 1);
  end

  // squaring operand and unit requests per state
  always_comb begin
    sq_op        = '0;
    req.start    = 1'b0;
    req.sqrt     = 1'b0;
    req.rem_init = '0;
    req.src      = scf_pkg::ONE2_SRC;
    req.divisor  = '0;
    req.nsteps   = scf_pkg::STEPS_RECIP;
    case (state_r)
      ST_SQ_X: sq_op = scf_pkg::DIFF_W'(mag_x_r);
      ST_SQ_Y: sq_op = scf_pkg::DIFF_W'(mag_y_r);
      ST_SQ_Z: sq_op = scf_pkg::DIFF_W'(mag_z_r);
      ST_TERM: sq_op = diff_cl;
      ST_ROOT: begin
        req.start  = 1'b1;
        req.sqrt   = 1'b1;
        req.src    = {d2_r, {(scf_pkg::DV_W-scf_pkg::D2_W){1'b0}}};
        req.nsteps = scf_pkg::STEPS_ROOT;
      end
      ST_RD: begin
        req.start   = 1'b1;
        req.divisor = scf_pkg::RW'(d_r);
      end
      ST_RS: begin
        req.start   = 1'b1;
        req.divisor = scf_pkg::RW'(s_r);
      end
      ST_FACT: begin
        req.start    = 1'b1;
        req.rem_init = scf_pkg::RW'(fdiv >> scf_pkg::FACT_W);
        req.src      = fdiv << (scf_pkg::DV_W - scf_pkg::FACT_W);
        req.divisor  = scf_pkg::RW'(den);
        req.nsteps   = scf_pkg::STEPS_FACT;
      end
      default: sq_op = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    score_nxt = score_r;
    sat_nxt   = sat_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_atom_present) state_nxt = ST_SQ_X;
          else if (in_last_atom) state_nxt = ST_FACT;
        end
      end
      ST_SQ_X:   state_nxt = ST_SQ_Y;
      ST_SQ_Y:   state_nxt = ST_SQ_Z;
      ST_SQ_Z:   state_nxt = ST_SQ_ACC;
      ST_SQ_ACC: state_nxt = ST_ROOT;
      ST_ROOT:   state_nxt = ST_ROOT_W;
      ST_ROOT_W: begin
        if (rsp.done) begin
          if (scf_pkg::SUM_W'(root) >= s_r || root >= scf_pkg::ROOT_W'(s_r))
            state_nxt = last_r ? ST_FACT : ST_IDLE;
          else
            state_nxt = ST_RD;
        end
      end
      ST_RD:     state_nxt = ST_RD_W;
      ST_RD_W:   if (rsp.done) state_nxt = ST_RS;
      ST_RS:     state_nxt = ST_RS_W;
      ST_RS_W:   if (rsp.done) state_nxt = ST_TERM;
      ST_TERM:   state_nxt = ST_ACCUM;
      ST_ACCUM: begin
        if (sum_wide > (scf_pkg::PROD_W+1)'(scf_pkg::SCORE_MAX)) begin
          score_nxt = scf_pkg::SCORE_MAX;
          sat_nxt   = 1'b1;
        end else begin
          score_nxt = sum_wide[scf_pkg::SCORE_W-1:0];
          if (sum_wide[scf_pkg::SCORE_W-1:0] == scf_pkg::SCORE_MAX) sat_nxt = 1'b1;
        end
        state_nxt = last_r ? ST_FACT : ST_IDLE;
      end
      ST_FACT:   state_nxt = ST_FACT_W;
      ST_FACT_W: if (rsp.done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          score_nxt = '0;
          sat_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      probe_r     <= scf_pkg::PROBE_RST;
      score_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      score_r <= score_nxt;
      sat_r   <= sat_nxt;
      if (cfg_wr_en) probe_r <= cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_x_r <= dx;
      mag_y_r <= dy;
      mag_z_r <= dz;
      s_r     <= scf_pkg::SUM_W'(in_atom_radius) + scf_pkg::SUM_W'(probe_r);
      last_r  <= in_last_atom;
    end
    case (state_r)
      ST_SQ_Y:   d2_r <= sq_r[scf_pkg::D2_W-1:0];
      ST_SQ_Z:   d2_r <= d2_r + sq_r[scf_pkg::D2_W-1:0];
      ST_SQ_ACC: d2_r <= d2_r + sq_r[scf_pkg::D2_W-1:0];
      ST_ROOT_W: begin
        if (rsp.done)
          d_r <= (root == '0) ? scf_pkg::SUM_W'(1) : root[scf_pkg::SUM_W-1:0];
      end
      ST_RD_W:   if (rsp.done) inv_d_r <= rsp.quot[scf_pkg::RECIP_W-1:0];
      ST_RS_W:   if (rsp.done) inv_s_r <= rsp.quot[scf_pkg::RECIP_W-1:0];
      ST_FACT_W: if (rsp.done) fact_r <= rsp.quot[scf_pkg::FACT_W-1:0];
      default: ;
    endcase
    if (out_load) begin
      out_fact_r <= fact_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_clash_factor    = out_fact_r;
  assign out_score_saturated = out_sat_r;

  // checks
  `SCF_ASSERT(a_sat_max, sat_r |-> (score_r == scf_pkg::SCORE_MAX), "flag set below max score")
  `SCF_ASSERT(a_unit_idle, (state_r == ST_IDLE) |-> !rsp.busy, "unit busy while idle")
  `SCF_ASSERT_NEXT(a_clear, out_load, (score_r == '0) && !sat_r, "score not cleared")
  `SCF_ASSERT(a_fact_range, out_valid_r |-> (out_fact_r <= scf_pkg::FACT_ONE), "factor above one")

endmodule
